@@ rtl/pphs_pkg.sv @@
// ----------------------------------------------------------------------------
// pphs_pkg
// Shared types and constants for the power/phase to hermitian spectrum core.
// ----------------------------------------------------------------------------
`default_nettype none

package pphs_pkg;

  localparam int MAX_FFT_LOG2   = 10;
  localparam int MIN_FFT_LOG2   = 2;
  localparam int CFG_W          = 4;
  localparam logic [CFG_W-1:0] FFT_LOG2_RESET = 4'd9;

  localparam int BIN_W          = 10;
  localparam int POW_W          = 32;
  localparam int PH_W           = 16;
  localparam int MAG_W          = 16;
  localparam int RE_W           = 17;
  localparam int SIZE_W         = MAX_FFT_LOG2 + 1;

  localparam int SQRT_STAGES    = 8;
  localparam int CORDIC_STEPS   = 16;
  localparam int CORDIC_STAGES  = 8;
  localparam int PROD_W         = 32;
  localparam int XW             = 35;
  localparam int ZW             = 33;
  localparam logic [MAG_W-1:0] GAIN_INV = 16'd39797;

  localparam int IN_TDATA_W     = 64;
  localparam int OUT_TDATA_W    = 48;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4,
    33'sh0028B0D43, 33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55,
    33'sh00028BE53, 33'sh000145F2E, 33'sh0000A2F98, 33'sh0000517CC,
    33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2F9, 33'sh00000517C
  };

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [BIN_W-1:0] mbin;
    logic             mirror;
  } tag_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvec_t;

endpackage

`default_nettype wire

@@ rtl/pphs_sqrt.sv @@
// ----------------------------------------------------------------------------
// pphs_sqrt
// Pipelined 32-bit integer square root, two restoring steps per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pphs_sqrt import pphs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [POW_W-1:0] power,
  input  logic [PH_W-1:0]  phase,
  input  tag_t             tag_in,
  output logic             out_valid,
  output logic [MAG_W-1:0] mag,
  output logic [PH_W-1:0]  phase_out,
  output tag_t             tag_out
);

  typedef struct packed {
    logic [POW_W-1:0] num;
    logic [POW_W-1:0] res;
  } sq_t;

  function automatic sq_t sqrt_step(input sq_t v, input int k);
    sq_t              r;
    logic [POW_W-1:0] bitv;
    logic [POW_W:0]   trial;
    bitv  = POW_W'(1) << (POW_W - 2 - 2 * k);
    trial = {1'b0, v.res} + {1'b0, bitv};
    if ({1'b0, v.num} >= trial) begin
      r.num = v.num - trial[POW_W-1:0];
      r.res = (v.res >> 1) + bitv;
    end else begin
      r.num = v.num;
      r.res = v.res >> 1;
    end
    return r;
  endfunction

  sq_t             st  [SQRT_STAGES];
  sq_t             src [SQRT_STAGES];
  sq_t             nxt [SQRT_STAGES];
  logic            vld [SQRT_STAGES];
  logic [PH_W-1:0] ph  [SQRT_STAGES];
  tag_t            tg  [SQRT_STAGES];

  always_comb begin
    src[0].num = power;
    src[0].res = '0;
    for (int s = 1; s < SQRT_STAGES; s++) begin
      src[s] = st[s-1];
    end
    for (int s = 0; s < SQRT_STAGES; s++) begin
      nxt[s] = sqrt_step(sqrt_step(src[s], 2 * s), 2 * s + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SQRT_STAGES; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s < SQRT_STAGES; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph[0] <= phase;
      tg[0] <= tag_in;
      for (int s = 1; s < SQRT_STAGES; s++) begin
        ph[s] <= ph[s-1];
        tg[s] <= tg[s-1];
      end
      for (int s = 0; s < SQRT_STAGES; s++) st[s] <= nxt[s];
    end
  end

  assign out_valid = vld[SQRT_STAGES-1];
  assign mag       = st[SQRT_STAGES-1].res[MAG_W-1:0];
  assign phase_out = ph[SQRT_STAGES-1];
  assign tag_out   = tg[SQRT_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/pphs_cordic.sv @@
// ----------------------------------------------------------------------------
// pphs_cordic
// Gain multiply, quadrant fold, 16-step rotation CORDIC and Q16 rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module pphs_cordic import pphs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [MAG_W-1:0]       mag,
  input  logic [PH_W-1:0]        phase,
  input  tag_t                   tag_in,
  output logic                   out_valid,
  output logic signed [RE_W-1:0] re,
  output logic signed [RE_W-1:0] im,
  output tag_t                   tag_out
);

  function automatic cvec_t rot(input cvec_t v, input int k);
    cvec_t                r;
    logic signed [XW-1:0] xs, ys, dx, dy;
    logic signed [ZW-1:0] zs;
    xs = v.x;
    ys = v.y;
    zs = v.z;
    dx = ys >>> k;
    dy = xs >>> k;
    if (!zs[ZW-1]) begin
      r.x = xs - dx;
      r.y = ys + dy;
      r.z = zs - ATAN_TAB[k];
    end else begin
      r.x = xs + dx;
      r.y = ys - dy;
      r.z = zs + ATAN_TAB[k];
    end
    return r;
  endfunction

  function automatic logic signed [RE_W-1:0] round_sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = (v + XW'(32768)) >>> 16;
    if (t > XW'(65535)) return RE_W'(65535);
    if (t < XW'(-65536)) return RE_W'(-65536);
    return t[RE_W-1:0];
  endfunction

  // stage 0: gain multiply and angle fold
  logic              flip;
  logic [PH_W-1:0]   af;
  logic [PROD_W-1:0] prod;
  logic              neg;
  logic [ZW-1:0]     z0;
  logic              v0;
  tag_t              t0;

  assign flip = phase[PH_W-1] ^ phase[PH_W-2];
  assign af   = {phase[PH_W-1] ^ flip, phase[PH_W-2:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(mag) * PROD_W'(GAIN_INV);
      neg  <= flip;
      z0   <= {{(ZW-PH_W-16){af[PH_W-1]}}, af, 16'b0};
      t0   <= tag_in;
    end
  end

  // rotation stages
  cvec_t                cv  [CORDIC_STAGES];
  cvec_t                src [CORDIC_STAGES];
  cvec_t                nxt [CORDIC_STAGES];
  logic                 cvl [CORDIC_STAGES];
  tag_t                 ctg [CORDIC_STAGES];
  logic signed [XW-1:0] xseed;

  assign xseed = neg ? -$signed({{(XW-PROD_W){1'b0}}, prod})
                     :  $signed({{(XW-PROD_W){1'b0}}, prod});

  always_comb begin
    src[0].x = xseed;
    src[0].y = '0;
    src[0].z = z0;
    for (int c = 1; c < CORDIC_STAGES; c++) begin
      src[c] = cv[c-1];
    end
    for (int c = 0; c < CORDIC_STAGES; c++) begin
      nxt[c] = rot(rot(src[c], 2 * c), 2 * c + 1);
    end
  end

  logic rvld;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      rvld <= 1'b0;
      for (int c = 0; c < CORDIC_STAGES; c++) cvl[c] <= 1'b0;
    end else if (en) begin
      v0     <= in_valid;
      cvl[0] <= v0;
      for (int c = 1; c < CORDIC_STAGES; c++) cvl[c] <= cvl[c-1];
      rvld   <= cvl[CORDIC_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctg[0] <= t0;
      for (int c = 1; c < CORDIC_STAGES; c++) ctg[c] <= ctg[c-1];
      for (int c = 0; c < CORDIC_STAGES; c++) cv[c] <= nxt[c];
      re      <= round_sat(cv[CORDIC_STAGES-1].x);
      im      <= round_sat(cv[CORDIC_STAGES-1].y);
      tag_out <= ctg[CORDIC_STAGES-1];
    end
  end

  assign out_valid = rvld;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(rvld) && $stable(re) && $stable(im))
    else $error("cordic output moved while stalled");

endmodule

`default_nettype wire

@@ rtl/pphs_mirror.sv @@
// ----------------------------------------------------------------------------
// pphs_mirror
// Output register: sends the bin beat and, where needed, its conjugate mirror.
// ----------------------------------------------------------------------------
`default_nettype none

module pphs_mirror import pphs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tag_t                   in_tag,
  input  logic signed [RE_W-1:0] in_re,
  input  logic signed [RE_W-1:0] in_im,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // out_bin, real_part, imag_part
  output logic                   m_tlast   // last_of_run
);

  logic            hv;
  logic            phase;
  tag_t            h_tag;
  logic [RE_W-1:0] h_re;
  logic [RE_W-1:0] h_im;
  logic [RE_W-1:0] h_imn;
  logic            take;
  logic            done;
  logic [BIN_W-1:0] obin;
  logic [RE_W-1:0] oim;

  assign m_tlast  = phase | ~h_tag.mirror;
  assign take     = hv & m_tready;
  assign done     = take & m_tlast;
  assign in_ready = ~hv | done;

  always_ff @(posedge clk) begin
    if (rst) begin
      hv    <= 1'b0;
      phase <= 1'b0;
    end else if (in_valid && in_ready) begin
      hv    <= 1'b1;
      phase <= 1'b0;
    end else if (take) begin
      if (m_tlast) begin
        hv <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      h_tag <= in_tag;
      h_re  <= in_re;
      h_im  <= in_im;
      h_imn <= (in_im == RE_W'(-65536)) ? RE_W'(65535) : -in_im;
    end
  end

  assign obin     = phase ? h_tag.mbin : h_tag.bin;
  assign oim      = phase ? h_imn : h_im;
  assign m_tvalid = hv;
  assign m_tdata  = {{(OUT_TDATA_W-BIN_W-2*RE_W){1'b0}}, oim, h_re, obin};

  a_second_beat: assert property (@(posedge clk) disable iff (rst)
    hv && m_tready && !m_tlast |=> hv && phase)
    else $error("mirror beat not presented after first beat");

  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> hv && !phase)
    else $error("accepted result not held");

  a_mirror_only: assert property (@(posedge clk) disable iff (rst)
    hv && phase |-> h_tag.mirror)
    else $error("mirror beat for a bin without mirror");

endmodule

`default_nettype wire

@@ rtl/power_phase_to_hermitian_spectrum_core.sv @@
// Each input beat passes the sqrt, CORDIC and mirror registers before its first
// result beat; the mirror beat follows in the next cycle when the sink is ready.
// Throughput: one bin per cycle for bins 0 and N/2 while the sink is ready;
// mirror beats share the single result port; bins above N/2 give no beat.
// Reset clears all valid bits and sets fft_size_log2 to 9.
// ----------------------------------------------------------------------------
// power_phase_to_hermitian_spectrum_core
// Power/phase bin to complex value with conjugate mirror for a real IFFT.
// ----------------------------------------------------------------------------
`default_nettype none

module power_phase_to_hermitian_spectrum_core import pphs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // bin_index, power, phase_angle
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // out_bin, real_part, imag_part
  output logic                   m_tlast    // last_of_run
);

  logic [CFG_W-1:0]  fft_size_log2;
  logic [CFG_W-1:0]  lg;
  logic [SIZE_W-1:0] n;
  logic [SIZE_W-1:0] half;
  logic [SIZE_W-1:0] mdiff;
  logic [BIN_W-1:0]  bin;
  logic [POW_W-1:0]  power;
  logic [PH_W-1:0]   phase_angle;
  logic              keep;
  tag_t              tag_in;
  logic              en;

  always_ff @(posedge clk) begin
    if (rst) begin
      fft_size_log2 <= FFT_LOG2_RESET;
    end else if (cfg_we) begin
      fft_size_log2 <= cfg_wdata;
    end
  end

  assign lg = (fft_size_log2 < CFG_W'(MIN_FFT_LOG2)) ? CFG_W'(MIN_FFT_LOG2) :
              (fft_size_log2 > CFG_W'(MAX_FFT_LOG2)) ? CFG_W'(MAX_FFT_LOG2) :
              fft_size_log2;
  assign n    = SIZE_W'(1) << lg;
  assign half = n >> 1;

  assign bin         = s_tdata[BIN_W-1:0];
  assign power       = s_tdata[BIN_W+POW_W-1:BIN_W];
  assign phase_angle = s_tdata[BIN_W+POW_W+PH_W-1:BIN_W+POW_W];

  assign keep          = {1'b0, bin} <= half;
  assign mdiff         = n - {1'b0, bin};
  assign tag_in.bin    = bin;
  assign tag_in.mbin   = mdiff[BIN_W-1:0];
  assign tag_in.mirror = (bin != '0) && ({1'b0, bin} != half);

  logic             sq_valid;
  logic [MAG_W-1:0] sq_mag;
  logic [PH_W-1:0]  sq_phase;
  tag_t             sq_tag;

  pphs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid & keep),
    .power     (power),
    .phase     (phase_angle),
    .tag_in    (tag_in),
    .out_valid (sq_valid),
    .mag       (sq_mag),
    .phase_out (sq_phase),
    .tag_out   (sq_tag)
  );

  logic                   cr_valid;
  logic signed [RE_W-1:0] cr_re;
  logic signed [RE_W-1:0] cr_im;
  tag_t                   cr_tag;
  logic                   mr_ready;

  pphs_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .mag       (sq_mag),
    .phase     (sq_phase),
    .tag_in    (sq_tag),
    .out_valid (cr_valid),
    .re        (cr_re),
    .im        (cr_im),
    .tag_out   (cr_tag)
  );

  assign en       = ~cr_valid | mr_ready;
  assign s_tready = en;

  pphs_mirror u_mirror (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cr_valid),
    .in_ready (mr_ready),
    .in_tag   (cr_tag),
    .in_re    (cr_re),
    .in_im    (cr_im),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

@@ sim/pphs_spectrum_checker.sv @@
// ----------------------------------------------------------------------------
// pphs_spectrum_checker
// Watches both streams of the hermitian spectrum core, predicts every result
// beat from each accepted bin (integer sqrt, 16-step rotation, rounding and
// saturation, conjugate mirror) and compares them in order, field by field.
// ----------------------------------------------------------------------------
module pphs_spectrum_checker import pphs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // bin_index, power, phase_angle
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // out_bin, real_part, imag_part
  input  logic                   m_tlast,   // last_of_run
  output int                     mismatches,
  output int                     spec_pending,
  output int                     beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ROT_GAIN_INV = 39797;

  typedef struct {
    logic [BIN_W-1:0]       bin;
    logic signed [RE_W-1:0] re;
    logic signed [RE_W-1:0] im;
    logic                   last;
  } spec_beat_t;

  spec_beat_t       spec_q[$];
  logic [CFG_W-1:0] fft_log2;

  // atan(2^-k) with pi = 2^31
  function automatic longint rot_angle(int k);
    case (k)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2E;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2F9;
      default: return 64'h0000517C;
    endcase
  endfunction

  function automatic logic [MAG_W-1:0] root_floor(logic [POW_W-1:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem  = {32'd0, v};
    root = 0;
    b    = 64'h4000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root[MAG_W-1:0];
  endfunction

  function automatic logic signed [RE_W-1:0] clip17(longint v);
    if (v > 65535) return 17'sd65535;
    if (v < -65536) return -17'sd65536;
    return v[RE_W-1:0];
  endfunction

  function automatic void predict_bin(logic [IN_TDATA_W-1:0] d);
    logic [BIN_W-1:0]    bin;
    logic [POW_W-1:0]    pw;
    logic signed [PH_W-1:0] ph;
    int                  lg;
    longint              n, half, a, x, y, z, dx, dy;
    logic signed [RE_W-1:0] re, im;
    spec_beat_t          e;
    lg = fft_log2;
    if (lg < MIN_FFT_LOG2) lg = MIN_FFT_LOG2;
    if (lg > MAX_FFT_LOG2) lg = MAX_FFT_LOG2;
    n    = 64'sd1 << lg;
    half = n >> 1;
    bin  = d[BIN_W-1:0];
    pw   = d[BIN_W+POW_W-1:BIN_W];
    ph   = d[BIN_W+POW_W+PH_W-1:BIN_W+POW_W];
    if (longint'(bin) > half) return;
    x = longint'({48'd0, root_floor(pw)}) * ROT_GAIN_INV;
    y = 0;
    a = ph;
    if (a >= 16384) begin
      a = a - 32768;
      x = -x;
    end else if (a < -16384) begin
      a = a + 32768;
      x = -x;
    end
    z = a * 65536;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - rot_angle(k);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + rot_angle(k);
      end
    end
    re = clip17((x + 32768) >>> 16);
    im = clip17((y + 32768) >>> 16);
    e.bin = bin;
    e.re  = re;
    e.im  = im;
    if (bin == 0 || longint'(bin) == half) begin
      e.last = 1'b1;
      spec_q.push_back(e);
    end else begin
      e.last = 1'b0;
      spec_q.push_back(e);
      e.bin  = BIN_W'(n - longint'(bin));
      e.im   = clip17(-longint'(im));
      e.last = 1'b1;
      spec_q.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] spectrum mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    spec_beat_t want;
    logic signed [RE_W-1:0] got_re, got_im;
    if (rst) begin
      fft_log2 = FFT_LOG2_RESET;
      spec_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got_re = m_tdata[BIN_W+RE_W-1:BIN_W];
        got_im = m_tdata[BIN_W+2*RE_W-1:BIN_W+RE_W];
        beats_checked++;
        if (spec_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat bin %0d re %0d im %0d",
                                    m_tdata[BIN_W-1:0], got_re, got_im));
        end else begin
          want = spec_q.pop_front();
          if (m_tdata[BIN_W-1:0] !== want.bin)
            report_mismatch($sformatf("out_bin %0d, want %0d",
                                      m_tdata[BIN_W-1:0], want.bin));
          if (got_re !== want.re)
            report_mismatch($sformatf("bin %0d real %0d, want %0d",
                                      want.bin, got_re, want.re));
          if (got_im !== want.im)
            report_mismatch($sformatf("bin %0d imag %0d, want %0d",
                                      want.bin, got_im, want.im));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("bin %0d tlast %b, want %b",
                                      want.bin, m_tlast, want.last));
        end
      end
      // a bin accepted on the write edge still sees the old setting
      if (s_tvalid && s_tready) predict_bin(s_tdata);
      if (cfg_we) fft_log2 = cfg_wdata;
    end
    spec_pending = spec_q.size();
  end

endmodule

@@ sim/power_phase_to_hermitian_spectrum_core_tb.sv @@
// ----------------------------------------------------------------------------
// power_phase_to_hermitian_spectrum_core_tb
// Drives directed and random spectral bins through the core under a series
// of fft_size_log2 settings (in range, extremes and out-of-range codes), with
// random idle bursts on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module power_phase_to_hermitian_spectrum_core_tb import pphs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 30;
  localparam int BINS_PER_PHASE = 66;
  localparam int NUM_CFG = 10;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // bin_index, power, phase_angle
  logic                   m_tvalid;
  logic                   m_tready  = 1'b1;
  logic [OUT_TDATA_W-1:0] m_tdata;          // out_bin, real_part, imag_part
  logic                   m_tlast;          // last_of_run

  int mismatches;
  int spec_pending;
  int beats_checked;

  bit stall_on = 1'b0;
  int hold_rx  = 0;
  logic [CFG_W-1:0] lg_now;
  int bins_sent   = 0;
  int bins_beyond = 0;
  int fft_log2_plan [NUM_CFG] = '{2, 10, 0, 15, 5, 1, 11, 7, 3, 10};

  power_phase_to_hermitian_spectrum_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  pphs_spectrum_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .spec_pending  (spec_pending),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_rx == 0 && stall_on && $urandom_range(0, 5) == 0)
      hold_rx = $urandom_range(1, 10);
    if (hold_rx > 0) begin
      m_tready <= 1'b0;
      hold_rx--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic int half_bins(logic [CFG_W-1:0] v);
    int l;
    l = v;
    if (l < MIN_FFT_LOG2) l = MIN_FFT_LOG2;
    if (l > MAX_FFT_LOG2) l = MAX_FFT_LOG2;
    return 1 << (l - 1);
  endfunction

  task automatic send_bin(input logic [BIN_W-1:0] bin, input logic [POW_W-1:0] pw,
                          input logic [PH_W-1:0] ph);
    s_tdata  <= {{(IN_TDATA_W-BIN_W-POW_W-PH_W){1'b0}}, ph, pw, bin};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    bins_sent++;
    if (bin > half_bins(lg_now)) bins_beyond++;
    if (stall_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // stop sending, wait for every expected beat, then let ignored bins clear
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (spec_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fft_log2(input logic [CFG_W-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lg_now = v;
  endtask

  task automatic random_bins(input int want, input bit idle_ok);
    int got;
    int half;
    int pick;
    logic [BIN_W-1:0] b;
    logic [POW_W-1:0] pw;
    logic [PH_W-1:0]  ph;
    got  = 0;
    half = half_bins(lg_now);
    while (got < want) begin
      if (got % 40 == 0) stall_on = idle_ok && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) b = '0;
      else if (pick < 16) b = BIN_W'(half);
      else if (pick < 24) b = BIN_W'($urandom_range(half + 1, 1023));
      else b = BIN_W'($urandom_range(1, half - 1));
      case ($urandom_range(0, 7))
        0:       pw = '0;
        1:       pw = '1;
        2, 3:    pw = POW_W'($urandom_range(0, 65535));
        default: pw = $urandom;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 7))
          0: ph = 16'h8000;
          1: ph = 16'h7FFF;
          2: ph = 16'h4000;
          3: ph = 16'h3FFF;
          4: ph = 16'hC000;
          5: ph = 16'hBFFF;
          6: ph = 16'h0000;
          default: ph = 16'hFFFF;
        endcase
      end else begin
        ph = PH_W'($urandom);
      end
      send_bin(b, pw, ph);
      if (b <= half) got++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    lg_now   = FFT_LOG2_RESET;
    stall_on = 1'b1;

    // reset setting, N = 512: DC, Nyquist, edges of the mirror range,
    // ignored bins, quadrant folds and full-scale magnitude
    send_bin(10'd0,    32'd0,          16'h0000);
    send_bin(10'd256,  32'hFFFF_FFFF,  16'h0000);
    send_bin(10'd1,    32'hFFFF_FFFF,  16'hC000);
    send_bin(10'd255,  32'hFFFF_FFFF,  16'h4000);
    send_bin(10'd257,  32'hFFFF_FFFF,  16'h1234);
    send_bin(10'd1023, 32'hFFFF_FFFF,  16'h8000);
    send_bin(10'd2,    32'hFFFF_FFFF,  16'h8000);
    send_bin(10'd3,    32'hFFFF_FFFF,  16'h7FFF);
    send_bin(10'd4,    32'hFFFF_FFFF,  16'h3FFF);
    send_bin(10'd5,    32'hFFFF_FFFF,  16'hBFFF);
    send_bin(10'd6,    32'd1,          16'd100);
    send_bin(10'd7,    32'h0001_0000,  16'hFFFF);
    send_bin(10'd8,    32'hFFFF_FFFE,  16'hC001);
    send_bin(10'd100,  32'hFFFF_FFFF,  16'h2000);
    send_bin(10'd170,  32'hAAAA_AAAA,  16'h5555);
    send_bin(10'd85,   32'h5555_5555,  16'hAAAA);
    send_bin(10'd0,    32'hFFFF_FFFF,  16'hC000);
    send_bin(10'd256,  32'h8000_0000,  16'h8000);
    random_bins(BINS_PER_PHASE, 1'b1);

    for (int p = 0; p < NUM_CFG; p++) begin
      drain();
      write_fft_log2(CFG_W'(fft_log2_plan[p]));
      random_bins(BINS_PER_PHASE, p != NUM_CFG - 1);
    end
    stall_on = 1'b0;
    drain();

    $display("Sent %0d bins (%0d above N/2) over %0d fft_size_log2 settings.",
             bins_sent, bins_beyond, NUM_CFG + 1);
    $display("Checked %0d result beats, %0d mismatches.", beats_checked, mismatches);
    if (mismatches == 0)
      $display("power_phase_to_hermitian_spectrum_core_tb: PASS");
    else
      $display("power_phase_to_hermitian_spectrum_core_tb: FAIL");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d beats still expected.", spec_pending);
    $display("power_phase_to_hermitian_spectrum_core_tb: FAIL");
    $finish;
  end

endmodule
